FILE: src/gbfp_pkg.sv
// shared types, state codes and helpers of the binary frame parser
package gbfp_pkg;

  // parser state codes, also reported as next_expect
  localparam logic [3:0] ST_SYNC1   = 4'd0;
  localparam logic [3:0] ST_SYNC2   = 4'd1;
  localparam logic [3:0] ST_CLASS   = 4'd2;
  localparam logic [3:0] ST_ID      = 4'd3;
  localparam logic [3:0] ST_LEN_LO  = 4'd4;
  localparam logic [3:0] ST_LEN_HI  = 4'd5;
  localparam logic [3:0] ST_PAYLOAD = 4'd6;
  localparam logic [3:0] ST_CK_A    = 4'd7;
  localparam logic [3:0] ST_CK_B    = 4'd8;

  // register indexes on the configuration port
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  // reset values of the sync byte registers
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h62;

  // widths of the stream data words
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 64;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  next_expect;
    logic        consumed;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_done;
    logic        checksum_ok;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic        known_type;
  } result_t;

  // class and id pairs of the six recognized messages
  function automatic logic is_known(input logic [7:0] cls, input logic [7:0] id);
    logic hit;
    hit = ((cls == 8'h05) && (id == 8'h01)) ||
          ((cls == 8'h05) && (id == 8'h00)) ||
          ((cls == 8'h06) && (id == 8'h3E)) ||
          ((cls == 8'h06) && (id == 8'h01)) ||
          ((cls == 8'h01) && (id == 8'h07)) ||
          ((cls == 8'h01) && (id == 8'h35));
    return hit;
  endfunction

endpackage

FILE: src/gbfp_cfg_regs.sv
// configuration registers behind the apb-style port
module gbfp_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output gbfp_pkg::cfg_t    cfg_o
);
  import gbfp_pkg::*;

  logic [7:0] sync_first_q, sync_first_d;
  logic [7:0] sync_second_q, sync_second_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write decode
  always_comb begin
    sync_first_d  = sync_first_q;
    sync_second_d = sync_second_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_SYNC_FIRST:  sync_first_d  = pwdata[7:0];
        REG_SYNC_SECOND: sync_second_d = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else begin
      sync_first_q  <= sync_first_d;
      sync_second_q <= sync_second_d;
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[2])
      REG_SYNC_FIRST:  prdata = {24'd0, sync_first_q};
      REG_SYNC_SECOND: prdata = {24'd0, sync_second_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o.sync_first  = sync_first_q;
  assign cfg_o.sync_second = sync_second_q;

endmodule

FILE: src/gbfp_core.sv
// frame state machine, checksum and per-byte result logic
module gbfp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  gbfp_pkg::cfg_t    cfg_i,
  output gbfp_pkg::result_t res_o
);
  import gbfp_pkg::*;

  logic [3:0]  state_q, state_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  ck_a_q, ck_a_d;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] count_inc;
  logic [15:0] len_full;

  // fletcher step and length helpers
  assign add_a     = sum_a_q + byte_i;
  assign add_b     = sum_b_q + add_a;
  assign count_inc = count_q + 16'd1;
  assign len_full  = {byte_i, len_q[7:0]};

  // next state and result for the byte at hand
  always_comb begin
    state_d = state_q;
    class_d = class_q;
    id_d    = id_q;
    len_d   = len_q;
    count_d = count_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    ck_a_d  = ck_a_q;

    res_o.consumed      = 1'b0;
    res_o.payload_valid = 1'b0;
    res_o.payload_byte  = 8'd0;
    res_o.payload_index = 16'd0;
    res_o.frame_done    = 1'b0;
    res_o.checksum_ok   = 1'b0;
    res_o.known_type    = 1'b0;

    unique case (state_q)
      ST_SYNC1: begin
        if (byte_i == cfg_i.sync_first) begin
          class_d = 8'd0;
          id_d    = 8'd0;
          len_d   = 16'd0;
          count_d = 16'd0;
          sum_a_d = 8'd0;
          sum_b_d = 8'd0;
          ck_a_d  = 8'd0;
          state_d = ST_SYNC2;
          res_o.consumed = 1'b1;
        end
      end
      ST_SYNC2: begin
        if (byte_i == cfg_i.sync_second) begin
          state_d = ST_CLASS;
          res_o.consumed = 1'b1;
        end else begin
          state_d = ST_SYNC1;
        end
      end
      ST_CLASS: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        class_d = byte_i;
        state_d = ST_ID;
        res_o.consumed = 1'b1;
      end
      ST_ID: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        id_d    = byte_i;
        state_d = ST_LEN_LO;
        res_o.consumed = 1'b1;
      end
      ST_LEN_LO: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        len_d   = {8'd0, byte_i};
        state_d = ST_LEN_HI;
        res_o.consumed = 1'b1;
      end
      ST_LEN_HI: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        len_d   = len_full;
        count_d = 16'd0;
        state_d = (len_full == 16'd0) ? ST_CK_A : ST_PAYLOAD;
        res_o.consumed = 1'b1;
      end
      ST_PAYLOAD: begin
        sum_a_d = add_a;
        sum_b_d = add_b;
        count_d = count_inc;
        if (count_inc == len_q) begin
          state_d = ST_CK_A;
        end
        res_o.consumed      = 1'b1;
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = byte_i;
        res_o.payload_index = count_q;
      end
      ST_CK_A: begin
        ck_a_d  = byte_i;
        state_d = ST_CK_B;
        res_o.consumed = 1'b1;
      end
      ST_CK_B: begin
        state_d = ST_SYNC1;
        res_o.consumed    = 1'b1;
        res_o.frame_done  = 1'b1;
        res_o.checksum_ok = (ck_a_q == sum_a_q) && (byte_i == sum_b_q);
        res_o.known_type  = is_known(class_q, id_q);
      end
      default: begin
        state_d = ST_SYNC1;
      end
    endcase

    res_o.next_expect  = state_d;
    res_o.frame_class  = class_d;
    res_o.frame_id     = id_d;
    res_o.frame_length = len_d;
  end

  // frame state, advanced once per byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC1;
      class_q <= 8'd0;
      id_q    <= 8'd0;
      len_q   <= 16'd0;
      count_q <= 16'd0;
      sum_a_q <= 8'd0;
      sum_b_q <= 8'd0;
      ck_a_q  <= 8'd0;
    end else if (step_i) begin
      state_q <= state_d;
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      count_q <= count_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      ck_a_q  <= ck_a_d;
    end
  end

  // payload bytes never run past the declared length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (state_q == ST_PAYLOAD)) |-> (count_q < len_q))
    else $error("payload count reached declared length in payload state");

  // a zero length never enters the payload state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (state_q == ST_LEN_HI) && (len_full == 16'd0)) |=> (state_q == ST_CK_A))
    else $error("zero length frame did not go to checksum");

  // a finished frame always returns to the hunt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (state_q == ST_CK_B)) |=> (state_q == ST_SYNC1))
    else $error("parser did not restart hunt after frame end");

endmodule

FILE: src/gbfp_out_reg.sv
// result register toward the master-side stream
module gbfp_out_reg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  gbfp_pkg::result_t                res_i,
  output logic                             ready_o,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gbfp_pkg::OutDataW-1:0]    m_tdata,
  output logic                             m_tlast,
  output logic                             m_tuser
);
  import gbfp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // room when empty or when the held item leaves this cycle
  assign ready_o = !valid_q || m_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_tvalid = valid_q;
  assign m_tlast  = res_q.frame_done;
  assign m_tuser  = res_q.payload_valid;
  assign m_tdata  = {1'b0,
                     res_q.known_type,
                     res_q.frame_length,
                     res_q.frame_id,
                     res_q.frame_class,
                     res_q.checksum_ok,
                     res_q.payload_index,
                     res_q.payload_byte,
                     res_q.consumed,
                     res_q.next_expect};

endmodule

FILE: src/gnss_binary_frame_parser_top.sv
// top level of the binary frame parser: input register, parser, result register
//
// Usage: received bytes enter one per item on the slave-side stream
// (s_tdata[7:0] = byte_in). Each byte yields exactly one result item on the
// master-side stream. m_tlast marks the second checksum byte of a frame
// (frame_done) and m_tuser flags a payload byte (payload_valid); m_tdata
// carries the remaining result fields.
// An accepted byte sits in the input register, and the combinational parser
// logic writes its result into the result register once that register has
// room; the result item is then shown on the master-side stream.
// Throughput is one byte per cycle while the receiver does not stall; the
// parser updates its state and checksum sums once per byte.
// The sync byte values are set through the apb-style port (0x0 first sync,
// 0x4 second sync) and should be changed only while the block is idle.
// Reset returns the parser to hunting the first sync byte, clears the frame
// registers and restores the default sync values 0xB5 and 0x62.
// When the receiver stalls the result register holds its item, the input
// register takes one more byte, and then s_tready drops until room frees.
module gnss_binary_frame_parser_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb-style configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // slave-side stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [7:0] byte_in
  input  logic [gbfp_pkg::InDataW-1:0]  s_tdata,
  // master-side stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [3:0] next_expect, [4] consumed, [12:5] payload_byte, [28:13] payload_index,
  // [29] checksum_ok, [37:30] frame_class, [45:38] frame_id,
  // [61:46] frame_length, [62] known_type, [63] zero
  output logic [gbfp_pkg::OutDataW-1:0] m_tdata,
  // frame_done
  output logic                          m_tlast,
  // [0] payload_valid
  output logic                          m_tuser
);
  import gbfp_pkg::*;

  cfg_t       cfg;
  result_t    res;
  logic       out_ready;
  logic       step;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  gbfp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register, moves on when the result register has room
  assign step     = in_valid_q && out_ready;
  assign s_tready = !in_valid_q || out_ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_tvalid && s_tready) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      in_byte_q <= s_tdata;
    end
  end

  gbfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  gbfp_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .res_i    (res),
    .ready_o  (out_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // a frame end result always reports the hunt state next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tlast) |-> (m_tdata[3:0] == ST_SYNC1))
    else $error("frame done without return to hunt");

  // a payload byte is always part of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tuser) |-> (m_tdata[4] && !m_tlast))
    else $error("payload item not consumed or marked as frame end");

  // a byte held in the input register with a free output moves on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !m_tvalid) |=> m_tvalid)
    else $error("result register did not take a waiting item");

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the binary frame parser: directed table, random frames, apb setup
`timescale 1ns / 1ps

module testbench;
  import gbfp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_ITEMS    = 45;

  // class/id pairs of the recognized messages
  localparam logic [5:0][15:0] KNOWN_PAIRS = {
    16'h0501, 16'h0500, 16'h063E, 16'h0601, 16'h0107, 16'h0135
  };

  // control fields that a directed row may pin down
  typedef struct packed {
    logic [3:0] next_expect;
    logic       consumed;
    logic       frame_done;
    logic       checksum_ok;
    logic       known_type;
  } ctrl_t;

  typedef struct packed {
    logic [7:0] data;
    bit         typed;
    ctrl_t      ctrl;
  } dir_row_t;

  localparam ctrl_t NO_CTRL = '0;

  // directed bytes: junk, bad second sync, zero-length known frame, payload frame with bad checksum
  localparam dir_row_t DIRECTED_ROWS [22] = '{
    '{8'h00, 1'b1, '{ST_SYNC1,   1'b0, 1'b0, 1'b0, 1'b0}},
    '{8'hFF, 1'b1, '{ST_SYNC1,   1'b0, 1'b0, 1'b0, 1'b0}},
    '{8'hB5, 1'b1, '{ST_SYNC2,   1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'hB5, 1'b1, '{ST_SYNC1,   1'b0, 1'b0, 1'b0, 1'b0}},
    '{8'hB5, 1'b1, '{ST_SYNC2,   1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'h62, 1'b1, '{ST_CLASS,   1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'h05, 1'b0, NO_CTRL},
    '{8'h01, 1'b0, NO_CTRL},
    '{8'h00, 1'b0, NO_CTRL},
    '{8'h00, 1'b1, '{ST_CK_A,    1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'h06, 1'b1, '{ST_CK_B,    1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'h17, 1'b1, '{ST_SYNC1,   1'b1, 1'b1, 1'b1, 1'b1}},
    '{8'hB5, 1'b1, '{ST_SYNC2,   1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'h62, 1'b1, '{ST_CLASS,   1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, NO_CTRL},
    '{8'hFF, 1'b0, NO_CTRL},
    '{8'h02, 1'b0, NO_CTRL},
    '{8'h00, 1'b0, NO_CTRL},
    '{8'h00, 1'b0, NO_CTRL},
    '{8'hFF, 1'b0, NO_CTRL},
    '{8'h00, 1'b1, '{ST_CK_B,    1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'h00, 1'b1, '{ST_SYNC1,   1'b1, 1'b1, 1'b0, 1'b0}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] byte_in
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // [3:0] next_expect, [4] consumed, [12:5] payload_byte, ...
  logic        m_tlast;   // frame_done
  logic        m_tuser;   // [0] payload_valid

  gnss_binary_frame_parser_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // parser copy: sync settings and frame state
  logic [7:0]  sync_first_cfg  = SYNC_FIRST_RST;
  logic [7:0]  sync_second_cfg = SYNC_SECOND_RST;
  logic [3:0]  ps_state  = ST_SYNC1;
  logic [7:0]  ps_class  = '0;
  logic [7:0]  ps_id     = '0;
  logic [15:0] ps_length = '0;
  logic [15:0] ps_count  = '0;
  logic [7:0]  ps_sum_a  = '0;
  logic [7:0]  ps_sum_b  = '0;
  logic [7:0]  ps_ck_a   = '0;

  result_t     pending_results [$];
  int unsigned errors        = 0;
  int unsigned frame_bytes   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned frames_done   = 0;
  int unsigned frames_ok     = 0;
  int unsigned frames_known  = 0;
  int unsigned payload_seen  = 0;
  int unsigned idle_cycles   = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  bit          hold_request  = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic known_pair(input logic [7:0] cls, input logic [7:0] id);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (KNOWN_PAIRS[i] == {cls, id}) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic void fletcher_add(input logic [7:0] b);
    ps_sum_a = ps_sum_a + b;
    ps_sum_b = ps_sum_b + ps_sum_a;
  endfunction

  // next parser state and result for one received byte
  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (ps_state)
      ST_SYNC1: begin
        if (b == sync_first_cfg) begin
          ps_class  = '0;
          ps_id     = '0;
          ps_length = '0;
          ps_count  = '0;
          ps_sum_a  = '0;
          ps_sum_b  = '0;
          ps_ck_a   = '0;
          ps_state  = ST_SYNC2;
          r.consumed = 1'b1;
        end
      end
      ST_SYNC2: begin
        if (b == sync_second_cfg) begin
          ps_state   = ST_CLASS;
          r.consumed = 1'b1;
        end else begin
          ps_state = ST_SYNC1;
        end
      end
      ST_CLASS: begin
        fletcher_add(b);
        ps_class   = b;
        ps_state   = ST_ID;
        r.consumed = 1'b1;
      end
      ST_ID: begin
        fletcher_add(b);
        ps_id      = b;
        ps_state   = ST_LEN_LO;
        r.consumed = 1'b1;
      end
      ST_LEN_LO: begin
        fletcher_add(b);
        ps_length  = {8'h00, b};
        ps_state   = ST_LEN_HI;
        r.consumed = 1'b1;
      end
      ST_LEN_HI: begin
        fletcher_add(b);
        ps_length  = {b, ps_length[7:0]};
        ps_count   = '0;
        ps_state   = (ps_length == 16'd0) ? ST_CK_A : ST_PAYLOAD;
        r.consumed = 1'b1;
      end
      ST_PAYLOAD: begin
        fletcher_add(b);
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = ps_count;
        ps_count = ps_count + 16'd1;
        if (ps_count == ps_length) ps_state = ST_CK_A;
        r.consumed = 1'b1;
      end
      ST_CK_A: begin
        ps_ck_a    = b;
        ps_state   = ST_CK_B;
        r.consumed = 1'b1;
      end
      ST_CK_B: begin
        r.frame_done  = 1'b1;
        r.checksum_ok = (ps_ck_a == ps_sum_a) && (b == ps_sum_b);
        r.known_type  = known_pair(ps_class, ps_id);
        ps_state      = ST_SYNC1;
        r.consumed    = 1'b1;
      end
      default: ps_state = ST_SYNC1;
    endcase
    r.next_expect  = ps_state;
    r.frame_class  = ps_class;
    r.frame_id     = ps_id;
    r.frame_length = ps_length;
    return r;
  endfunction

  // offer one byte with random sender gaps, predict its result once taken
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input ctrl_t ctrl = '0);
    result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk_i); while (!s_tready);
    r = parse_byte(b);
    if (typed) begin
      r.next_expect = ctrl.next_expect;
      r.consumed    = ctrl.consumed;
      r.frame_done  = ctrl.frame_done;
      r.checksum_ok = ctrl.checksum_ok;
      r.known_type  = ctrl.known_type;
    end
    pending_results.push_back(r);
    bytes_sent++;
    if (r.consumed) frame_bytes++;
  endtask

  // well-formed frame with random content, sometimes a corrupted checksum
  task automatic send_frame(input bit long_frame);
    logic [7:0]  body [$];
    logic [7:0]  cls, id, sa, sb;
    logic [15:0] len;
    cls = $urandom;
    id  = $urandom;
    if ($urandom_range(1)) {cls, id} = KNOWN_PAIRS[$urandom_range(5)];
    if (long_frame) len = 16'd256 + 16'($urandom_range(8));
    else if ($urandom_range(3) != 0) len = 16'($urandom_range(8));
    else len = 16'($urandom_range(40, 9));
    body = '{cls, id, len[7:0], len[15:8]};
    for (int i = 0; i < len; i++) body.push_back(8'($urandom));
    sa = '0;
    sb = '0;
    send_byte(sync_first_cfg);
    send_byte(sync_second_cfg);
    foreach (body[i]) begin
      send_byte(body[i]);
      sa = sa + body[i];
      sb = sb + sa;
    end
    if ($urandom_range(4) == 0) {sb, sa} = {sb, sa} ^ (16'd1 << $urandom_range(15));
    send_byte(sa);
    send_byte(sb);
  endtask

  task automatic write_reg(input logic reg_index, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_index == REG_SYNC_FIRST) sync_first_cfg = value;
    else sync_second_cfg = value;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic reg_index, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_index, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {24'h0, value}) begin
      $error("prdata: expected %0h, got %0h", {24'h0, value}, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering, then wait until every result is back and the pipeline is quiet
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni) begin
      idle_cycles++;
      if ((s_tvalid && s_tready) || (psel && penable && pready)) idle_cycles = 0;
      if (m_tvalid && m_tready) begin
        idle_cycles = 0;
        got.next_expect   = m_tdata[3:0];
        got.consumed      = m_tdata[4];
        got.payload_valid = m_tuser;
        got.payload_byte  = m_tdata[12:5];
        got.payload_index = m_tdata[28:13];
        got.frame_done    = m_tlast;
        got.checksum_ok   = m_tdata[29];
        got.frame_class   = m_tdata[37:30];
        got.frame_id      = m_tdata[45:38];
        got.frame_length  = m_tdata[61:46];
        got.known_type    = m_tdata[62];
        if (pending_results.size() == 0) begin
          $error("result item with no byte outstanding: %h", m_tdata);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("next_expect", 16'(want.next_expect), 16'(got.next_expect));
          check_field("consumed", 16'(want.consumed), 16'(got.consumed));
          check_field("payload_valid", 16'(want.payload_valid), 16'(got.payload_valid));
          check_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
          check_field("payload_index", want.payload_index, got.payload_index);
          check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
          check_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
          check_field("frame_class", 16'(want.frame_class), 16'(got.frame_class));
          check_field("frame_id", 16'(want.frame_id), 16'(got.frame_id));
          check_field("frame_length", want.frame_length, got.frame_length);
          check_field("known_type", 16'(want.known_type), 16'(got.known_type));
          if (want.frame_done) frames_done++;
          if (want.frame_done && want.checksum_ok) frames_ok++;
          if (want.frame_done && want.known_type) frames_known++;
          if (want.payload_valid) payload_seen++;
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0]  junk;
    int unsigned sel;
    rst_ni   <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of the sync registers
    check_reg(REG_SYNC_FIRST, SYNC_FIRST_RST);
    check_reg(REG_SYNC_SECOND, SYNC_SECOND_RST);

    // directed table
    foreach (DIRECTED_ROWS[i]) begin
      send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].ctrl);
    end

    // random phases: sync setting and idling pattern per phase
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_SYNC_FIRST, SYNC_FIRST_RST);
          write_reg(REG_SYNC_SECOND, SYNC_SECOND_RST);
          src_idle_pct = 0;  sink_stall_pct = 0;
        end
        1: begin
          write_reg(REG_SYNC_FIRST, 8'h00);
          write_reg(REG_SYNC_SECOND, 8'hFF);
          src_idle_pct = 83; sink_stall_pct = 0;
        end
        2: begin
          write_reg(REG_SYNC_FIRST, 8'hFF);
          write_reg(REG_SYNC_SECOND, 8'h00);
          src_idle_pct = 0;  sink_stall_pct = 83;
        end
        3: begin
          write_reg(REG_SYNC_FIRST, 8'($urandom));
          write_reg(REG_SYNC_SECOND, 8'($urandom));
          src_idle_pct = 34; sink_stall_pct = 34;
        end
        default: begin
          write_reg(REG_SYNC_FIRST, SYNC_FIRST_RST);
          write_reg(REG_SYNC_SECOND, SYNC_SECOND_RST);
          src_idle_pct = 0;  sink_stall_pct = 0;
        end
      endcase
      check_reg(REG_SYNC_FIRST, sync_first_cfg);
      check_reg(REG_SYNC_SECOND, sync_second_cfg);

      // last phase: long output hold-off while a long frame keeps coming
      if (ph == 4) begin
        hold_request = 1'b1;
        send_frame(1'b1);
      end

      while (bytes_sent < PHASE_ITEMS * (ph + 1)) begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          send_frame(1'b0);
        end else if (sel < 82) begin
          // first sync followed by a wrong second sync
          do junk = $urandom; while (junk == sync_second_cfg);
          send_byte(sync_first_cfg);
          send_byte(junk);
        end else begin
          // line noise between frames
          repeat ($urandom_range(4, 1)) begin
            do junk = $urandom; while (junk == sync_first_cfg);
            send_byte(junk);
          end
        end
      end
    end

    drain();
    repeat (10) @(posedge clk_i);

    $display("run: %0d bytes in, %0d in frames, %0d payload bytes, five sync settings",
             bytes_sent, frame_bytes, payload_seen);
    $display("run: %0d frames ended, %0d with good checksum, %0d of known type",
             frames_done, frames_ok, frames_known);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/gbfp_pkg.sv
src/gbfp_cfg_regs.sv
src/gbfp_core.sv
src/gbfp_out_reg.sv
src/gnss_binary_frame_parser_top.sv
sim/testbench.sv
